/* hw/rtl/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants for the button press qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

    localparam int TIME_W   = 32;
    localparam int DEB_W    = 10;
    localparam int WIN_W    = 13;
    localparam int HOLD_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = DEB_W'(50);
    localparam logic [WIN_W-1:0]   WINDOW_RST    = WIN_W'(400);
    localparam logic [HOLD_W-1:0]  LONG_HOLD_RST = HOLD_W'(5000);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = CFG_IDX_W'(2);

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [WIN_W-1:0]  multi_press_window_ms;
        logic [HOLD_W-1:0] long_hold_ms;
    } bpq_cfg_t;

    typedef struct packed {
        logic logging_on;
        logic clear_event;
        logic toggle_event;
        logic debounced_level;
    } bpq_result_t;

endpackage : bpq_pkg

`default_nettype wire

/* hw/rtl/button_press_qualifier.sv */
// ----------------------------------------------------------------------------
// button_press_qualifier
// Debounces an active-low button and qualifies short-press groups and
// long presses from timestamped samples.
// ----------------------------------------------------------------------------
//  channel  | ports                          | contents
//  ---------+--------------------------------+------------------------------------
//  s_*      | s_tvalid s_tready s_tdata[39:0] | [31:0] now_ms, [32] button_level
//  m_*      | m_tvalid m_tready m_tdata[7:0]  | [0] debounced, [1] toggle,
//           |                                | [2] clear, [3] logging_on
//  cfg_*    | cfg_valid cfg_ready cfg_index   | 0 debounce, 1 window, 2 long hold
//           | cfg_data[15:0]                 |
//
// One request per cycle unless the output stalls; m_tvalid is set when the sample register steps.
// The sample register feeds the step logic, whose result lands in the output
// register in the same cycle the state advances.
// rst_n clears state, config to defaults; cfg_ready is always high.
// A stalled output holds its result; the sample register keeps taking a new
// request whenever its content moves on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_qualifier (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [bpq_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] now_ms, [32] button_level
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [bpq_pkg::OUT_DATA_W-1:0]   m_tdata,   // [0] debounced_level,
                                                             // [1] toggle_event,
                                                             // [2] clear_event, [3] logging_on
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [bpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpq_pkg::*;

    bpq_cfg_t    cfg;
    bpq_result_t result;

    logic              in_valid_reg, in_valid_next;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_level_reg;
    logic              out_valid_reg, out_valid_next;
    bpq_result_t       out_data_reg;
    logic              step;
    logic              s_fire;

    assign cfg_ready = 1'b1;

    bpq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bpq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .now_ms       (in_now_reg),
        .button_level (in_level_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_comb
    begin
        step           = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || step;
        s_fire         = s_tvalid && s_tready;
        in_valid_next  = s_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = step ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_now_reg   <= s_tdata[TIME_W-1:0];
            in_level_reg <= s_tdata[TIME_W];
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule : button_press_qualifier

`default_nettype wire

/* hw/rtl/bpq_cfg.sv */
// ----------------------------------------------------------------------------
// bpq_cfg
// Configuration register file: debounce, grouping window, long-hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [bpq_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [bpq_pkg::CFG_DATA_W-1:0] wr_data,
    output bpq_pkg::bpq_cfg_t                  cfg
);
    import bpq_pkg::*;

    bpq_cfg_t cfg_reg;
    bpq_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DEBOUNCE:  cfg_next.debounce_ms           = wr_data[DEB_W-1:0];
                REG_WINDOW:    cfg_next.multi_press_window_ms = wr_data[WIN_W-1:0];
                REG_LONG_HOLD: cfg_next.long_hold_ms          = wr_data[HOLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms           <= DEBOUNCE_RST;
            cfg_reg.multi_press_window_ms <= WINDOW_RST;
            cfg_reg.long_hold_ms          <= LONG_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : bpq_cfg

`default_nettype wire

/* hw/rtl/bpq_core.sv */
// ----------------------------------------------------------------------------
// bpq_core
// Per-tick state update: debounce, long press, multi-press grouping.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [bpq_pkg::TIME_W-1:0] now_ms,
    input  wire logic                       button_level,
    input  wire bpq_pkg::bpq_cfg_t          cfg,
    output bpq_pkg::bpq_result_t            result
);
    import bpq_pkg::*;

    logic               raw_seen_reg,    raw_seen_next;
    logic               stable_seen_reg, stable_seen_next;
    logic [TIME_W-1:0]  last_change_reg, last_change_next;
    logic [TIME_W-1:0]  press_start_reg, press_start_next;
    logic [TIME_W-1:0]  last_release_reg, last_release_next;
    logic [COUNT_W-1:0] pending_reg,     pending_next;
    logic               long_done_reg,   long_done_next;
    logic               logging_reg,     logging_next;

    logic [TIME_W-1:0]  change_age;
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  held_eff;
    logic [TIME_W-1:0]  release_age;
    logic [TIME_W-1:0]  deb_ext;
    logic [TIME_W-1:0]  win_ext;
    logic [TIME_W-1:0]  hold_ext;
    logic               raw_change;
    logic               deb_fire;
    logic               press_fire;
    logic               short_release;
    logic               in_window;
    logic [COUNT_W-1:0] pending_a;
    logic               long_done_a;
    logic               clear_ev;
    logic               toggle_ev;

    always_comb
    begin
        deb_ext  = TIME_W'(cfg.debounce_ms);
        win_ext  = TIME_W'(cfg.multi_press_window_ms);
        hold_ext = TIME_W'(cfg.long_hold_ms);

        raw_change  = (button_level != raw_seen_reg);
        change_age  = now_ms - last_change_reg;
        held        = now_ms - press_start_reg;
        release_age = now_ms - last_release_reg;

        // a fresh raw change resets the age to zero, so it can never fire here
        deb_fire   = !raw_change && (change_age > deb_ext) && (stable_seen_reg != raw_seen_reg);
        press_fire = deb_fire && !raw_seen_reg;
        stable_seen_next = deb_fire ? raw_seen_reg : stable_seen_reg;

        short_release = deb_fire && raw_seen_reg && !long_done_reg && (held < hold_ext);
        in_window     = (release_age <= win_ext);

        if (short_release)
        begin
            if (in_window)
                pending_a = (pending_reg == COUNT_MAX) ? COUNT_MAX : pending_reg + COUNT_W'(1);
            else
                pending_a = COUNT_W'(1);
        end
        else
        begin
            pending_a = pending_reg;
        end

        long_done_a = press_fire ? 1'b0 : long_done_reg;
        held_eff    = press_fire ? '0 : held;

        clear_ev  = !stable_seen_next && !long_done_a && (held_eff >= hold_ext);
        // a short release this tick restarts the window, so no toggle yet
        toggle_ev = stable_seen_next && !short_release && (pending_a != '0)
                    && (release_age > win_ext);

        raw_seen_next     = button_level;
        last_change_next  = (raw_change || deb_fire) ? now_ms : last_change_reg;
        press_start_next  = press_fire ? now_ms : press_start_reg;
        last_release_next = short_release ? now_ms : last_release_reg;
        pending_next      = (clear_ev || toggle_ev) ? '0 : pending_a;
        long_done_next    = clear_ev ? 1'b1 : long_done_a;

        if (clear_ev)
            logging_next = 1'b0;
        else if (toggle_ev)
            logging_next = ~logging_reg;
        else
            logging_next = logging_reg;

        result.debounced_level = stable_seen_next;
        result.toggle_event    = toggle_ev;
        result.clear_event     = clear_ev;
        result.logging_on      = logging_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_seen_reg     <= 1'b1;
            stable_seen_reg  <= 1'b1;
            last_change_reg  <= '0;
            press_start_reg  <= '0;
            last_release_reg <= '0;
            pending_reg      <= '0;
            long_done_reg    <= 1'b0;
            logging_reg      <= 1'b0;
        end
        else if (step)
        begin
            raw_seen_reg     <= raw_seen_next;
            stable_seen_reg  <= stable_seen_next;
            last_change_reg  <= last_change_next;
            press_start_reg  <= press_start_next;
            last_release_reg <= last_release_next;
            pending_reg      <= pending_next;
            long_done_reg    <= long_done_next;
            logging_reg      <= logging_next;
        end
    end

endmodule : bpq_core

`default_nettype wire

/* hw/rtl/bpq_checker.sv */
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks on the button press qualifier's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bpq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bpq_pkg::*;

    // clear needs the button down, toggle needs it up
    a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("toggle and clear in one result");

    a_clear_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (!m_tdata[0] && !m_tdata[3]))
        else $error("clear with button up or logging on");

    a_toggle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("toggle while button down");

    // logging only changes with an event
    a_logging_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready ##1 m_tvalid && !m_tdata[1] && !m_tdata[2]
            && $past(m_tvalid, 1) && $past(m_tready, 1))
        |-> (m_tdata[3] == $past(m_tdata[3], 1)))
        else $error("logging flag changed without an event");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule : bpq_checker

bind button_press_qualifier bpq_checker u_bpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
